>>> rtl/terc_pkg.sv
// Shared types and constants for the time-of-flight event ROI counter.
// Used by terc_sat_counter and tof_event_roi_counter_core; no dependencies.
package terc_pkg;

   // Field widths of the stream payloads and configuration registers
   localparam int SWEEP_WIDTH   = 32;
   localparam int CHANNEL_WIDTH = 3;
   localparam int TOF_WIDTH     = 32;
   localparam int BIN_WIDTH     = 17;
   localparam int TOTAL_WIDTH   = 32;
   localparam int REGEN_WIDTH   = 2;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REGION_MAX    = 3;
   localparam int NUM_TOTALS    = 2 + REGION_MAX;

   localparam int REQ_FIELDS_WIDTH = SWEEP_WIDTH + CHANNEL_WIDTH + TOF_WIDTH;
   localparam int REQ_DATA_WIDTH   = ((REQ_FIELDS_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH   = NUM_TOTALS * TOTAL_WIDTH;

   // Channel codes
   localparam logic [CHANNEL_WIDTH-1:0] CH_START = 3'd6;
   localparam logic [CHANNEL_WIDTH-1:0] CH_STOP  = 3'd1;

   localparam logic [TOF_WIDTH-1:0] TOF_LIMIT_RESET = 32'd1000000;

   // Item kind carried on req_tuser
   typedef enum logic {
      CMD_EVENT = 1'b0,
      CMD_EOF   = 1'b1
   } terc_cmd_type;

   // Configuration register indexes
   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      REG_ROI0_LOW        = 3'd0,
      REG_ROI0_HIGH       = 3'd1,
      REG_ROI1_LOW        = 3'd2,
      REG_ROI1_HIGH       = 3'd3,
      REG_ROI2_LOW        = 3'd4,
      REG_ROI2_HIGH       = 3'd5,
      REG_TOF_LIMIT       = 3'd6,
      REG_REGIONS_ENABLED = 3'd7
   } terc_csr_reg_type;

   localparam terc_csr_reg_type ROI_LOW_INDEX [REGION_MAX] =
      '{REG_ROI0_LOW, REG_ROI1_LOW, REG_ROI2_LOW};
   localparam terc_csr_reg_type ROI_HIGH_INDEX [REGION_MAX] =
      '{REG_ROI0_HIGH, REG_ROI1_HIGH, REG_ROI2_HIGH};

   // Control of one saturating event counter
   typedef struct packed {
      logic inc;
      logic clear;
   } terc_cnt_ctl_type;

endpackage

>>> rtl/terc_sat_counter.sv
// Saturating event counter with synchronous clear.
// Depends on terc_pkg for the counter control struct.
module terc_sat_counter
   import terc_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  terc_cnt_ctl_type       ctl,
   output logic [COUNT_WIDTH-1:0] count
);

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;

   // Clear wins; hold at all ones once reached
   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.inc && (count_ff != {COUNT_WIDTH{1'b1}})) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

>>> rtl/tof_event_roi_counter_core.sv
// Top level of the time-of-flight event ROI counter: input stage, start/stop
// classification, region window match, counters and result register.
// Depends on terc_pkg and terc_sat_counter.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  req     | in        | req_tvalid/req_tready| tuser: command; tdata: sweep,channel,tof
//  rsp     | out       | rsp_tvalid/rsp_tready| tdata: start,stop,region0..2 totals
//  csr     | in        | csr_valid/csr_ready  | csr_addr register index, csr_wdata
//
// One item per clock while the input does not stall. An item is registered
// on acceptance and an event is processed in the next cycle; an end-of-file
// item loads the result register and sets rsp_tvalid when it leaves the
// input stage. Event items never wait; an end-of-file item waits in the
// input stage while an earlier result is still unread, and the input then
// stalls behind it. Reset is synchronous; item payload and result data are not reset.
module tof_event_roi_counter_core
   import terc_pkg::*;
#(
   parameter int REGION_SLOTS    = 3,
   parameter int COUNT_WIDTH     = 32,
   parameter int BIN_SCALE_SHIFT = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   // input transactions
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,  // sweep[31:0], channel[34:32], tof[66:35]
   input  logic                      req_tuser,  // command
   // result transactions
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,  // start, stop, region0, region1, region2
   // configuration writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int WIN_WIDTH = BIN_WIDTH + BIN_SCALE_SHIFT;

   // ---------------- configuration registers ----------------
   logic [BIN_WIDTH-1:0]   roi_low_ff [REGION_SLOTS];
   logic [BIN_WIDTH-1:0]   roi_high_ff [REGION_SLOTS];
   logic [TOF_WIDTH-1:0]   tof_limit_ff;
   logic [REGEN_WIDTH-1:0] regions_en_ff;
   logic                   csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // Write the scalar registers; region bounds are decoded per slot below
   always_ff @(posedge clock) begin
      if (reset) begin
         tof_limit_ff  <= TOF_LIMIT_RESET;
         regions_en_ff <= '0;
      end else if (csr_fire) begin
         case (terc_csr_reg_type'(csr_addr))
            REG_TOF_LIMIT:       tof_limit_ff  <= csr_wdata[TOF_WIDTH-1:0];
            REG_REGIONS_ENABLED: regions_en_ff <= csr_wdata[REGEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   for (genvar r = 0; r < REGION_SLOTS; r++) begin : g_roi_cfg
      always_ff @(posedge clock) begin
         if (reset) begin
            roi_low_ff[r]  <= '0;
            roi_high_ff[r] <= '0;
         end else if (csr_fire) begin
            if (csr_addr == ROI_LOW_INDEX[r]) begin
               roi_low_ff[r] <= csr_wdata[BIN_WIDTH-1:0];
            end
            if (csr_addr == ROI_HIGH_INDEX[r]) begin
               roi_high_ff[r] <= csr_wdata[BIN_WIDTH-1:0];
            end
         end
      end
   end

   // ---------------- input stage ----------------
   logic                     item_valid_ff;
   terc_cmd_type             item_cmd_ff;
   logic [SWEEP_WIDTH-1:0]   item_sweep_ff;
   logic [CHANNEL_WIDTH-1:0] item_channel_ff;
   logic [TOF_WIDTH-1:0]     item_tof_ff;
   logic                     req_fire;
   logic                     advance;
   logic                     rsp_valid_ff;
   logic                     eof_fire;

   // An end-of-file item needs a free result register; events always go
   assign advance = item_valid_ff &&
                    ((item_cmd_ff == CMD_EVENT) || !rsp_valid_ff || rsp_tready);
   assign eof_fire   = advance && (item_cmd_ff == CMD_EOF);
   assign req_tready = !item_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_cmd_ff     <= terc_cmd_type'(req_tuser);
         item_sweep_ff   <= req_tdata[SWEEP_WIDTH-1:0];
         item_channel_ff <= req_tdata[SWEEP_WIDTH +: CHANNEL_WIDTH];
         item_tof_ff     <= req_tdata[SWEEP_WIDTH+CHANNEL_WIDTH +: TOF_WIDTH];
      end
   end

   // ---------------- classification ----------------
   logic [SWEEP_WIDTH-1:0] prev_sweep_ff;
   logic                   first_of_file_ff;
   logic                   event_fire;
   logic                   is_start;
   logic                   is_stop;

   assign event_fire = advance && (item_cmd_ff == CMD_EVENT);
   assign is_start   = (item_channel_ff == CH_START) &&
                       (first_of_file_ff || (item_sweep_ff != prev_sweep_ff));
   assign is_stop    = (item_channel_ff == CH_STOP) && (item_tof_ff < tof_limit_ff);

   // Track the previous sweep; re-arm the first-event flag on end of file
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sweep_ff    <= '0;
         first_of_file_ff <= 1'b1;
      end else if (eof_fire) begin
         first_of_file_ff <= 1'b1;
      end else if (event_fire) begin
         prev_sweep_ff    <= item_sweep_ff;
         first_of_file_ff <= 1'b0;
      end
   end

   // ---------------- counters ----------------
   terc_cnt_ctl_type       start_ctl;
   terc_cnt_ctl_type       stop_ctl;
   logic [COUNT_WIDTH-1:0] start_count;
   logic [COUNT_WIDTH-1:0] stop_count;
   logic [COUNT_WIDTH-1:0] region_count [REGION_SLOTS];
   logic [TOTAL_WIDTH-1:0] totals [NUM_TOTALS];

   assign start_ctl.inc   = event_fire && is_start;
   assign start_ctl.clear = eof_fire;
   assign stop_ctl.inc    = event_fire && !is_start && is_stop;
   assign stop_ctl.clear  = eof_fire;

   terc_sat_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_start_cnt (
      .clock (clock),
      .reset (reset),
      .ctl   (start_ctl),
      .count (start_count)
   );

   terc_sat_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_stop_cnt (
      .clock (clock),
      .reset (reset),
      .ctl   (stop_ctl),
      .count (stop_count)
   );

   // Region windows: scaled bounds, inclusive on both ends
   for (genvar r = 0; r < REGION_SLOTS; r++) begin : g_region
      logic [WIN_WIDTH-1:0] win_low;
      logic [WIN_WIDTH-1:0] win_high;
      logic                 in_window;
      logic                 enabled;
      terc_cnt_ctl_type     ctl;

      assign win_low   = WIN_WIDTH'(roi_low_ff[r]) << BIN_SCALE_SHIFT;
      assign win_high  = WIN_WIDTH'(roi_high_ff[r]) << BIN_SCALE_SHIFT;
      assign in_window = (TOF_WIDTH'(win_low) <= item_tof_ff) &&
                         (item_tof_ff <= TOF_WIDTH'(win_high));
      assign enabled   = REGEN_WIDTH'(r) < regions_en_ff;
      assign ctl.inc   = stop_ctl.inc && enabled && in_window;
      assign ctl.clear = eof_fire;

      terc_sat_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_region_cnt (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .count (region_count[r])
      );
   end

   // ---------------- totals, clamped to the output width ----------------
   logic [COUNT_WIDTH-1:0] count_src [NUM_TOTALS];

   assign count_src[0] = start_count;
   assign count_src[1] = stop_count;
   for (genvar r = 0; r < REGION_MAX; r++) begin : g_src
      if (r < REGION_SLOTS) begin : g_used
         assign count_src[2+r] = region_count[r];
      end else begin : g_unused
         assign count_src[2+r] = '0;
      end
   end

   for (genvar t = 0; t < NUM_TOTALS; t++) begin : g_total
      if (COUNT_WIDTH > TOTAL_WIDTH) begin : g_clamp
         assign totals[t] = (|count_src[t][COUNT_WIDTH-1:TOTAL_WIDTH]) ?
                            {TOTAL_WIDTH{1'b1}} : count_src[t][TOTAL_WIDTH-1:0];
      end else begin : g_extend
         assign totals[t] = TOTAL_WIDTH'(count_src[t]);
      end
   end

   // ---------------- result register ----------------
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_in;

   always_comb begin
      for (int t = 0; t < NUM_TOTALS; t++) begin
         rsp_data_in[t*TOTAL_WIDTH +: TOTAL_WIDTH] = totals[t];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eof_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eof_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   // A result appears only after an end-of-file item left the input stage
   a_rsp_from_eof: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(eof_fire))
      else $error("result raised without an end-of-file item");

   // End of file clears the counts and re-arms the first-event flag
   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      eof_fire |=> (first_of_file_ff && (start_count == '0) && (stop_count == '0)))
      else $error("counts not cleared after end of file");

   // Every region hit is also a stop, so region 0 never passes the stop count
   a_region_le_stop: assert property (@(posedge clock) disable iff (reset)
      region_count[0] <= stop_count)
      else $error("region 0 count exceeds stop count");

   // An end-of-file item never overwrites an unread result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (eof_fire && rsp_valid_ff) |-> rsp_tready)
      else $error("result register overwritten while stalled");

endmodule

>>> bench/roi_count_checker.sv
// Checker for the time-of-flight event ROI counter: watches the request, result and
// register channels, predicts the totals of each file and compares every result.
// Depends on terc_pkg.
module roi_count_checker
   import terc_pkg::*;
#(
   parameter int REGION_SLOTS    = 3,
   parameter int COUNT_WIDTH     = 32,
   parameter int BIN_SCALE_SHIFT = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,  // sweep, channel, tof
   input  logic                      req_tuser,  // command
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_DATA_WIDTH-1:0] rsp_tdata,  // start, stop, region0, region1, region2
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   output int                        items_taken,
   output int                        writes_taken,
   output int                        results_checked,
   output int                        results_pending,
   output int                        fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] COUNT_MAX    = {64{1'b1}} >> (64 - COUNT_WIDTH);
   localparam logic [63:0] TOTAL_MAX    = 64'hFFFF_FFFF;

   typedef logic [NUM_TOTALS-1:0][TOTAL_WIDTH-1:0] totals_type;

   // Mirrored register settings
   logic [BIN_WIDTH-1:0]   region_floor   [REGION_MAX];
   logic [BIN_WIDTH-1:0]   region_ceiling [REGION_MAX];
   logic [TOF_WIDTH-1:0]   stop_tof_cap;
   logic [REGEN_WIDTH-1:0] regions_in_use;

   // Predicted counting state
   logic [SWEEP_WIDTH-1:0] sweep_seen;
   logic                   file_fresh;
   logic [63:0]            starts_counted;
   logic [63:0]            stops_counted;
   logic [63:0]            region_hits [REGION_MAX];
   totals_type             totals_due [$];

   function automatic logic [63:0] bump(input logic [63:0] count);
      return (count >= COUNT_MAX) ? COUNT_MAX : count + 64'd1;
   endfunction

   function automatic logic [TOTAL_WIDTH-1:0] clip(input logic [63:0] count);
      return (count > TOTAL_MAX) ? TOTAL_MAX[TOTAL_WIDTH-1:0] : count[TOTAL_WIDTH-1:0];
   endfunction

   function automatic string total_name(input int index);
      case (index)
         0: return "start_total";
         1: return "stop_total";
         2: return "region0_total";
         3: return "region1_total";
         default: return "region2_total";
      endcase
   endfunction

   task automatic clear_model();
      for (int r = 0; r < REGION_MAX; r++) begin
         region_floor[r]   = '0;
         region_ceiling[r] = '0;
         region_hits[r]    = '0;
      end
      stop_tof_cap   = TOF_LIMIT_RESET;
      regions_in_use = '0;
      sweep_seen     = '0;
      file_fresh     = 1'b1;
      starts_counted = '0;
      stops_counted  = '0;
      totals_due.delete();
   endtask

   // Apply one register write transaction
   task automatic take_write(input logic [CSR_ADDR_WIDTH-1:0] index,
                             input logic [CSR_DATA_WIDTH-1:0] value);
      case (index)
         REG_ROI0_LOW, REG_ROI1_LOW, REG_ROI2_LOW:
            region_floor[index >> 1] = value[BIN_WIDTH-1:0];
         REG_ROI0_HIGH, REG_ROI1_HIGH, REG_ROI2_HIGH:
            region_ceiling[index >> 1] = value[BIN_WIDTH-1:0];
         REG_TOF_LIMIT:
            stop_tof_cap = value[TOF_WIDTH-1:0];
         REG_REGIONS_ENABLED:
            regions_in_use = value[REGEN_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // Advance the counts by one accepted item; end of file queues the totals
   task automatic take_item(input logic cmd, input logic [REQ_DATA_WIDTH-1:0] data);
      logic [SWEEP_WIDTH-1:0]   sweep;
      logic [CHANNEL_WIDTH-1:0] channel;
      logic [TOF_WIDTH-1:0]     tof;
      logic [TOF_WIDTH-1:0]     lo;
      logic [TOF_WIDTH-1:0]     hi;
      totals_type               totals;
      sweep   = data[SWEEP_WIDTH-1:0];
      channel = data[SWEEP_WIDTH +: CHANNEL_WIDTH];
      tof     = data[SWEEP_WIDTH + CHANNEL_WIDTH +: TOF_WIDTH];
      if (cmd == CMD_EOF) begin
         totals[0] = clip(starts_counted);
         totals[1] = clip(stops_counted);
         for (int r = 0; r < REGION_MAX; r++) begin
            totals[2 + r]  = clip(region_hits[r]);
            region_hits[r] = '0;
         end
         totals_due = {totals_due, totals};
         starts_counted = '0;
         stops_counted  = '0;
         file_fresh     = 1'b1;
      end else begin
         if (channel == CH_START && (file_fresh || sweep != sweep_seen)) begin
            starts_counted = bump(starts_counted);
         end else if (channel == CH_STOP && tof < stop_tof_cap) begin
            stops_counted = bump(stops_counted);
            for (int r = 0; r < REGION_MAX; r++) begin
               if (r < regions_in_use && r < REGION_SLOTS) begin
                  lo = TOF_WIDTH'(region_floor[r]) << BIN_SCALE_SHIFT;
                  hi = TOF_WIDTH'(region_ceiling[r]) << BIN_SCALE_SHIFT;
                  if (lo <= tof && tof <= hi) region_hits[r] = bump(region_hits[r]);
               end
            end
         end
         sweep_seen = sweep;
         file_fresh = 1'b0;
      end
   endtask

   // Compare one result transaction with the oldest expectation
   task automatic check_result(input totals_type seen);
      totals_type want;
      if (totals_due.size() == 0) begin
         fail_count++;
         $display("%0t: result with nothing expected: %h", $time, seen);
      end else begin
         want = totals_due.pop_front();
         results_checked++;
         for (int i = 0; i < NUM_TOTALS; i++) begin
            if (seen[i] !== want[i]) begin
               fail_count++;
               $display("%0t: %s expected %h, got %h", $time, total_name(i), want[i],
                        seen[i]);
            end
         end
      end
   endtask

   // Sample all three channels on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
         items_taken     = 0;
         writes_taken    = 0;
         results_checked = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (csr_valid && csr_ready) begin
            take_write(csr_addr, csr_wdata);
            writes_taken++;
         end
         if (req_tvalid && req_tready) begin
            take_item(req_tuser, req_tdata);
            items_taken++;
         end
      end
      results_pending = totals_due.size();
   end

endmodule

>>> bench/tb.sv
// Top of the test bench for tof_event_roi_counter_core: drives event and end-of-file
// transactions, register writes and result back-pressure, and reports the verdict.
// Depends on terc_pkg, the core RTL and roi_count_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import terc_pkg::*;

   localparam int REGION_SLOTS    = 3;
   localparam int COUNT_WIDTH     = 32;
   localparam int BIN_SCALE_SHIFT = 3;
   localparam int SETTLE_CYCLES   = 6;
   localparam int JUNK_BITS       = CSR_DATA_WIDTH - BIN_WIDTH;
   localparam logic [BIN_WIDTH-1:0] BIN_MAX = {BIN_WIDTH{1'b1}};

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;  // sweep[31:0], channel[34:32], tof[66:35]
   logic                      req_tuser;  // command
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;  // start, stop, region0, region1, region2
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;

   int items_taken;
   int writes_taken;
   int results_checked;
   int results_pending;
   int fail_count;

   // Stimulus-side copy of the settings, used to aim tof values
   logic [BIN_WIDTH-1:0]   cfg_floor   [REGION_MAX];
   logic [BIN_WIDTH-1:0]   cfg_ceiling [REGION_MAX];
   logic [TOF_WIDTH-1:0]   cfg_limit;
   logic [REGEN_WIDTH-1:0] cfg_regions;
   logic [SWEEP_WIDTH-1:0] sweep_now;
   int                     sent_items;
   int                     settings_applied;
   int                     gap_odds;
   int                     stall_odds;
   int                     stall_left;
   int                     end_wait;

   tof_event_roi_counter_core #(
      .REGION_SLOTS    (REGION_SLOTS),
      .COUNT_WIDTH     (COUNT_WIDTH),
      .BIN_SCALE_SHIFT (BIN_SCALE_SHIFT)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   roi_count_checker #(
      .REGION_SLOTS    (REGION_SLOTS),
      .COUNT_WIDTH     (COUNT_WIDTH),
      .BIN_SCALE_SHIFT (BIN_SCALE_SHIFT)
   ) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .items_taken     (items_taken),
      .writes_taken    (writes_taken),
      .results_checked (results_checked),
      .results_pending (results_pending),
      .fail_count      (fail_count)
   );

   always #5 clock = ~clock;

   // Result back-pressure: random bursts of stalls on rsp_tready
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 9);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Hard stop if the run hangs
   initial begin
      #2_000_000;
      $display("timeout: %0d transactions in, %0d results outstanding", items_taken,
               results_pending);
      $display("tb: errors");
      $finish;
   end

   // Offer one item and hold it until the checker sees the transaction
   task automatic send_item(input terc_cmd_type cmd, input logic [SWEEP_WIDTH-1:0] sweep,
                            input logic [CHANNEL_WIDTH-1:0] channel,
                            input logic [TOF_WIDTH-1:0] tof);
      int target;
      target = items_taken + 1;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_DATA_WIDTH'({tof, channel, sweep});
      while (items_taken != target) @(negedge clock);
      sent_items++;
   endtask

   task automatic write_reg(input terc_csr_reg_type index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      int target;
      target = writes_taken + 1;
      csr_valid <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      while (writes_taken != target) @(negedge clock);
   endtask

   // Write every register from the stimulus copy, with junk above the used bits
   task automatic apply_settings();
      for (int r = 0; r < REGION_MAX; r++) begin
         write_reg(ROI_LOW_INDEX[r], {JUNK_BITS'($urandom()), cfg_floor[r]});
         write_reg(ROI_HIGH_INDEX[r], {JUNK_BITS'($urandom()), cfg_ceiling[r]});
      end
      write_reg(REG_TOF_LIMIT, cfg_limit);
      write_reg(REG_REGIONS_ENABLED,
                {(CSR_DATA_WIDTH - REGEN_WIDTH)'($urandom()), cfg_regions});
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // Hold off input until every expected result is out and the pipeline is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_window(input int r);
      cfg_floor[r] = BIN_WIDTH'($urandom_range(0, BIN_MAX));
      if ($urandom_range(0, 3) != 0)
         cfg_ceiling[r] = (cfg_floor[r] > BIN_MAX - 3000) ? BIN_MAX :
                          cfg_floor[r] + BIN_WIDTH'($urandom_range(0, 3000));
      else
         cfg_ceiling[r] = BIN_WIDTH'($urandom_range(0, BIN_MAX));
   endtask

   // Aim tof near window bounds and the stop limit, sometimes anywhere
   function automatic logic [TOF_WIDTH-1:0] pick_tof();
      int unsigned          roll;
      int unsigned          region;
      logic [TOF_WIDTH-1:0] bound;
      roll   = $urandom_range(0, 99);
      region = $urandom_range(0, REGION_MAX - 1);
      bound  = TOF_WIDTH'($urandom_range(0, 1) ? cfg_ceiling[region] : cfg_floor[region])
               << BIN_SCALE_SHIFT;
      if (roll < 50) return bound + TOF_WIDTH'($urandom_range(0, 4)) - TOF_WIDTH'(2);
      if (roll < 70 && cfg_limit != 0) return $urandom_range(0, cfg_limit - 1);
      if (roll < 85) return cfg_limit + TOF_WIDTH'($urandom_range(0, 4)) - TOF_WIDTH'(2);
      return $urandom();
   endfunction

   // Files of sweeps: a start, a few stops, some noise, then end of file
   task automatic run_files(input int quota);
      int goal;
      goal = sent_items + quota;
      while (sent_items < goal) begin
         repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 9) != 0)
               send_item(CMD_EVENT, sweep_now, CH_START, $urandom());
            repeat ($urandom_range(0, 5)) begin
               if ($urandom_range(0, 7) == 0)
                  send_item(CMD_EVENT, $urandom_range(0, 1) ? sweep_now : $urandom(),
                            CHANNEL_WIDTH'($urandom()), $urandom());
               else
                  send_item(CMD_EVENT, sweep_now, CH_STOP, pick_tof());
            end
            sweep_now = ($urandom_range(0, 3) != 0) ? sweep_now + 1 : $urandom();
         end
         send_item(CMD_EOF, $urandom(), CHANNEL_WIDTH'($urandom()), $urandom());
         if ($urandom_range(0, 7) == 0) settle();
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = CMD_EVENT;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_addr   = REG_ROI0_LOW;
      csr_wdata  = '0;
      stall_left = 0;
      sent_items = 0;
      settings_applied = 0;
      sweep_now  = $urandom();
      gap_odds   = 3;
      stall_odds = 8;
      for (int r = 0; r < REGION_MAX; r++) begin
         cfg_floor[r]   = '0;
         cfg_ceiling[r] = '0;
      end
      cfg_limit   = TOF_LIMIT_RESET;
      cfg_regions = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: start rules, stop limit, ignored channels, empty files
      send_item(CMD_EOF, '0, '0, '0);
      send_item(CMD_EVENT, '0, CH_START, '0);
      send_item(CMD_EVENT, '0, CH_START, '0);
      send_item(CMD_EVENT, '1, CH_START, '1);
      send_item(CMD_EVENT, '1, CH_STOP, '0);
      send_item(CMD_EVENT, '1, CH_STOP, TOF_LIMIT_RESET - 1);
      send_item(CMD_EVENT, '1, CH_STOP, TOF_LIMIT_RESET);
      send_item(CMD_EVENT, '1, CH_STOP, '1);
      send_item(CMD_EVENT, '0, 3'd7, '0);
      send_item(CMD_EVENT, '0, 3'd0, '1);
      send_item(CMD_EVENT, '0, CH_START, '0);
      send_item(CMD_EOF, 32'h1234_5678, CH_START, 32'hDEAD_BEEF);
      send_item(CMD_EVENT, '0, CH_START, '0);
      send_item(CMD_EOF, '1, '1, '1);
      settle();

      // Window edges, a single-bin window, an empty window, widest limit
      cfg_floor   = '{10, 20, 30};
      cfg_ceiling = '{20, 20, 25};
      cfg_limit   = '1;
      cfg_regions = 2'd3;
      apply_settings();
      send_item(CMD_EVENT, sweep_now, CH_STOP, 32'd79);
      send_item(CMD_EVENT, sweep_now, CH_STOP, 32'd80);
      send_item(CMD_EVENT, sweep_now, CH_STOP, 32'd160);
      send_item(CMD_EVENT, sweep_now, CH_STOP, 32'd161);
      send_item(CMD_EVENT, sweep_now, CH_STOP, 32'd240);
      send_item(CMD_EVENT, sweep_now, CH_STOP, 32'hFFFF_FFFE);
      send_item(CMD_EVENT, sweep_now, CH_STOP, 32'hFFFF_FFFF);
      send_item(CMD_EOF, sweep_now, CH_STOP, '0);
      run_files(270);
      settle();

      // Full-range and inverted windows, two regions, receiver stalls only
      gap_odds    = 0;
      stall_odds  = 5;
      cfg_floor[0]   = '0;
      cfg_ceiling[0] = BIN_MAX;
      cfg_floor[1]   = BIN_MAX;
      cfg_ceiling[1] = '0;
      random_window(2);
      cfg_limit   = TOF_LIMIT_RESET;
      cfg_regions = 2'd2;
      apply_settings();
      run_files(240);
      settle();

      // No stop can pass a zero limit; sender gaps only
      gap_odds   = 3;
      stall_odds = 0;
      for (int r = 0; r < REGION_MAX; r++) random_window(r);
      cfg_limit   = '0;
      cfg_regions = 2'd1;
      apply_settings();
      run_files(120);
      settle();

      // Only tof zero passes; region 0 is the single bin at zero
      gap_odds   = 5;
      stall_odds = 10;
      for (int r = 0; r < REGION_MAX; r++) random_window(r);
      cfg_floor[0]   = '0;
      cfg_ceiling[0] = '0;
      cfg_limit   = 32'd1;
      cfg_regions = 2'd3;
      apply_settings();
      run_files(120);
      settle();

      // All regions off, random limit
      gap_odds   = 4;
      stall_odds = 6;
      for (int r = 0; r < REGION_MAX; r++) random_window(r);
      cfg_limit   = $urandom_range(1, 2000000);
      cfg_regions = 2'd0;
      apply_settings();
      run_files(240);
      settle();

      // Final stretch at full rate on both sides
      gap_odds   = 0;
      stall_odds = 0;
      for (int r = 0; r < REGION_MAX; r++) random_window(r);
      cfg_limit   = $urandom_range(500000, 1100000);
      cfg_regions = 2'd3;
      apply_settings();
      run_files(240);

      // Drain and give the verdict
      req_tvalid <= 1'b0;
      end_wait = 0;
      while (results_pending != 0 && end_wait < 1000) begin
         @(negedge clock);
         end_wait++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("summary: %0d transactions in, %0d results checked, %0d register writes",
               items_taken, results_checked, writes_taken);
      $display("summary: %0d register settings besides reset values", settings_applied);
      if (results_pending != 0)
         $display("%0t: %0d expected results never arrived", $time, results_pending);
      if (fail_count == 0 && results_pending == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/terc_pkg.sv
rtl/terc_sat_counter.sv
rtl/tof_event_roi_counter_core.sv
bench/roi_count_checker.sv
bench/tb.sv
